### rtl/core/dsp_pkg.sv
// Constants and types shared by the duration text parser.
package dsp_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned SCALE_W = 17;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [SCALE_W-1:0] SCALE_SEC  = 17'd1;
    localparam logic [SCALE_W-1:0] SCALE_MIN  = 17'd60;
    localparam logic [SCALE_W-1:0] SCALE_HOUR = 17'd3600;
    localparam logic [SCALE_W-1:0] SCALE_DAY  = 17'd86400;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_S_LO = 8'h73;
    localparam logic [7:0] CH_S_UP = 8'h53;
    localparam logic [7:0] CH_M_LO = 8'h6d;
    localparam logic [7:0] CH_M_UP = 8'h4d;
    localparam logic [7:0] CH_H_LO = 8'h68;
    localparam logic [7:0] CH_H_UP = 8'h48;
    localparam logic [7:0] CH_D_LO = 8'h64;
    localparam logic [7:0] CH_D_UP = 8'h44;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_UNIT,
        CLS_BAD
    } char_class_t;

    typedef logic [VAL_W-1:0] val_t;

endpackage

### rtl/core/duration_string_parser.sv
// Duration text parser: characters in, total seconds out on the end item.
//
//  channel | dir | tdata                  | tuser                     | tlast
//  s_      | in  | [7:0] ch               | -                         | is_end
//  m_      | out | [30:0] total_seconds   | [0] bad_char [1] saturated| -
//
// One item per cycle while not stalled: an input register, then the state
// update and the result register, which an end item loads with its result.
// The multiply-add by the unit scale sets the clock period, not the item rate.
// rst_n clears the valid flags and parser state asynchronously; no clearing pass is needed.
// The input side stalls only while an end item waits on a full result register.
module duration_string_parser
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] total_seconds, [31] zero
    output logic [1:0]  m_tuser    // [0] bad_char, [1] saturated
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  ch_reg;
    logic        end_reg;

    val_t        pending_reg, pending_next;
    val_t        total_reg, total_next;
    logic        error_reg, error_next;
    logic        ovf_reg, ovf_next;

    logic        out_valid_reg, out_valid_next;
    val_t        out_total_reg;
    logic        out_bad_reg;
    logic        out_sat_reg;

    logic        advance;
    logic        item_go;
    logic        out_load;

    char_class_t cls;
    logic [SCALE_W-1:0] scale;
    logic [3:0]  digit;
    logic [34:0] pend_x10;
    logic [47:0] term_full;
    val_t        term;
    logic        term_ovf;
    logic [31:0] add_sum;
    logic [31:0] end_sum;
    val_t        end_total;

    assign advance  = !(in_valid_reg && end_reg && out_valid_reg && !m_tready);
    assign item_go  = in_valid_reg && advance;
    assign out_load = item_go && end_reg;
    assign s_tready = advance;

    always_comb
    begin
        cls   = CLS_BAD;
        scale = SCALE_SEC;
        case (ch_reg) inside
            [CH_ZERO:CH_NINE]:
            begin
                cls = CLS_DIGIT;
            end
            CH_S_LO, CH_S_UP:
            begin
                cls   = CLS_UNIT;
                scale = SCALE_SEC;
            end
            CH_M_LO, CH_M_UP:
            begin
                cls   = CLS_UNIT;
                scale = SCALE_MIN;
            end
            CH_H_LO, CH_H_UP:
            begin
                cls   = CLS_UNIT;
                scale = SCALE_HOUR;
            end
            CH_D_LO, CH_D_UP:
            begin
                cls   = CLS_UNIT;
                scale = SCALE_DAY;
            end
            default:
            begin
                cls = CLS_BAD;
            end
        endcase
    end

    always_comb
    begin
        digit     = 4'(ch_reg - CH_ZERO);
        pend_x10  = {1'b0, pending_reg, 3'b000} + {3'b000, pending_reg, 1'b0}
                    + {31'd0, digit};
        term_full = 48'(pending_reg) * 48'(scale);
        term_ovf  = |term_full[47:VAL_W];
        term      = term_ovf ? VAL_MAX : term_full[VAL_W-1:0];
        add_sum   = {1'b0, total_reg} + {1'b0, term};
        end_sum   = {1'b0, total_reg} + {1'b0, pending_reg};
        end_total = end_sum[31] ? VAL_MAX : end_sum[VAL_W-1:0];
    end

    always_comb
    begin
        pending_next = pending_reg;
        total_next   = total_reg;
        error_next   = error_reg;
        ovf_next     = ovf_reg;
        if (item_go)
        begin
            if (end_reg)
            begin
                pending_next = '0;
                total_next   = '0;
                error_next   = 1'b0;
                ovf_next     = 1'b0;
            end
            else if (!error_reg)
            begin
                case (cls)
                    CLS_DIGIT:
                    begin
                        if (|pend_x10[34:VAL_W])
                        begin
                            pending_next = VAL_MAX;
                            ovf_next     = 1'b1;
                        end
                        else
                        begin
                            pending_next = pend_x10[VAL_W-1:0];
                        end
                    end
                    CLS_UNIT:
                    begin
                        pending_next = '0;
                        total_next   = add_sum[31] ? VAL_MAX : add_sum[VAL_W-1:0];
                        ovf_next     = ovf_reg | term_ovf | add_sum[31];
                    end
                    default:
                    begin
                        error_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            total_reg     <= '0;
            error_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            error_reg     <= error_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && advance)
        begin
            ch_reg  <= s_tdata;
            end_reg <= s_tlast;
        end
        if (out_load)
        begin
            out_total_reg <= error_reg ? '0 : end_total;
            out_bad_reg   <= error_reg;
            out_sat_reg   <= ovf_reg | end_sum[31];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_total_reg};
    assign m_tuser  = {out_sat_reg, out_bad_reg};

`ifndef SYNTH
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (pending_reg == '0) && (total_reg == '0) && !error_reg && !ovf_reg)
        else $error("state not cleared after end item");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[VAL_W-1:0] == '0)
        else $error("bad text reported with nonzero total");

    a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        item_go && !end_reg && error_reg |=> $stable(pending_reg) && $stable(total_reg))
        else $error("state moved after a bad character");

    a_end_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("end item did not produce a result");
`endif

endmodule
